/* sv/julian_seconds_to_civil_time_assert.svh */
// julian_seconds_to_civil_time_assert.svh: assertion macros for the converter.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef JULIAN_SECONDS_TO_CIVIL_TIME_ASSERT_SVH
`define JULIAN_SECONDS_TO_CIVIL_TIME_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising clock edge outside reset.
`define JSCT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define JSCT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define JSCT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define JSCT_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* sv/jsct_pkg.sv */
`timescale 1ns / 1ps
// jsct_pkg: widths, reciprocal constants, status codes and field structs
// shared by all modules of the Julian seconds to civil time converter.
package jsct_pkg;

   // Input and intermediate widths
   localparam int unsigned SECS_W    = 39;
   localparam int unsigned SUM_W     = 40;
   localparam int unsigned DAY_NUM_W = 24;
   localparam int unsigned TOD_W     = 17;
   localparam int unsigned Z_W       = 23;
   localparam int unsigned DOE_W     = 18;

   // Half a day: Julian days start at noon
   localparam logic [SUM_W-1:0] TOD_BIAS = 40'd43200;

   // 86400 = 128 * 675; divide by 675 in a high and a low step
   localparam logic [9:0]  DAY_FRAC = 10'd675;
   localparam int unsigned XH_SH    = 31;
   localparam logic [21:0] XH_M     = 22'((64'd1 << XH_SH) / 64'd675 + 64'd1);
   localparam int unsigned V2_SH    = 32;
   localparam logic [22:0] V2_M     = 23'((64'd1 << V2_SH) / 64'd675 + 64'd1);

   // Day number of 1900-01-01 (noon-based, plus one) and shift to 0000-03-01
   localparam logic [DAY_NUM_W-1:0] DAY_BIAS = 24'd2415021;
   localparam logic [DAY_NUM_W-1:0] Z_OFS    = 24'd1721120;

   // Time of day
   localparam logic [TOD_W-1:0] SECS_PER_HOUR = 17'd3600;
   localparam int unsigned      HOUR_SH       = 29;
   localparam logic [17:0]      HOUR_M        = 18'((64'd1 << HOUR_SH) / 64'd3600 + 64'd1);
   localparam logic [11:0]      SECS_PER_MIN  = 12'd60;
   localparam int unsigned      MIN_SH        = 18;
   localparam logic [12:0]      MIN_M         = 13'((64'd1 << MIN_SH) / 64'd60 + 64'd1);

   // Calendar: 400-year eras and the corrections inside one era
   localparam logic [Z_W-1:0] ERA_DAYS = 23'd146097;
   localparam int unsigned    ERA_SH   = 41;
   localparam logic [23:0]    ERA_M    = 24'((64'd1 << ERA_SH) / 64'd146097 + 64'd1);
   localparam int unsigned    C4_SH    = 29;
   localparam logic [18:0]    C4_M     = 19'((64'd1 << C4_SH) / 64'd1460 + 64'd1);
   localparam int unsigned    C100_SH  = 34;
   localparam logic [18:0]    C100_M   = 19'((64'd1 << C100_SH) / 64'd36524 + 64'd1);
   localparam int unsigned    C400_SH  = 36;
   localparam logic [18:0]    C400_M   = 19'((64'd1 << C400_SH) / 64'd146096 + 64'd1);
   localparam int unsigned    Y_SH     = 27;
   localparam logic [18:0]    Y_M      = 19'((64'd1 << Y_SH) / 64'd365 + 64'd1);

   localparam logic [DOE_W-1:0] DAYS_PER_YEAR = 18'd365;
   localparam logic [13:0]      YEARS_PER_ERA = 14'd400;
   localparam logic [13:0]      MIN_YEAR      = 14'd1900;
   localparam logic [13:0]      MAX_YEAR      = 14'd9999;
   localparam logic [3:0]       MARCH_BASED   = 4'd10;

   // First day of each month in a year that starts on March 1
   localparam logic [8:0] MONTH_START [12] = '{
      9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
      9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
   };

   // Pipeline alignment of the time-of-day branch to the calendar branch
   localparam int unsigned TOD_ALIGN = 6;

   // Status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_BEFORE = 2'd1;
   localparam logic [1:0] STATUS_AFTER  = 2'd2;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] sec;
   } tod_fields_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  dom;
      logic [1:0]  status;
   } date_fields_type;

endpackage

/* sv/julian_seconds_to_civil_time.sv */
`timescale 1ns / 1ps
// julian_seconds_to_civil_time: top level of the Julian seconds to civil time converter.
// Depends on jsct_pkg, jsct_day_split, jsct_tod, jsct_date and the assert header.
//
// Channel    Ports                              Handshake
// request    start, busy, req_julian_secs       taken at an edge with start && !busy
// response   rsp_valid, rsp_year .. rsp_status  one-cycle strobe, no back-pressure
//
// One transaction enters every cycle while busy is low; the pipeline is fully overlapped.
// A result strobes once its request has passed 5 stages of the
// day/second split and 10 stages of the calendar path. The time-of-day path
// takes 4 stages and is delayed by 6 more to line up with the calendar path.
// busy is high only while reset is high; reset clears every valid bit and
// drops whatever was in flight. The receiver cannot stall, so nothing holds.
`include "julian_seconds_to_civil_time_assert.svh"

module julian_seconds_to_civil_time (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [38:0] req_julian_secs,
   output logic        rsp_valid,
   output logic [13:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second_of_minute,
   output logic [1:0]  rsp_status
);

   logic                            req_accept;
   logic                            split_valid;
   logic [jsct_pkg::DAY_NUM_W-1:0]  split_day_num;
   logic [jsct_pkg::TOD_W-1:0]      split_tod;
   jsct_pkg::tod_fields_type        tod_fields;
   jsct_pkg::tod_fields_type        tod_dly_ff [jsct_pkg::TOD_ALIGN];
   logic                            date_valid;
   jsct_pkg::date_fields_type       date_fields;

   // Hold off requests only while reset flushes the pipeline
   assign busy       = reset;
   assign req_accept = start && !busy;

   jsct_day_split u_day_split (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_accept),
      .in_secs     (req_julian_secs),
      .out_valid   (split_valid),
      .out_day_num (split_day_num),
      .out_tod     (split_tod)
   );

   jsct_tod u_tod (
      .clock      (clock),
      .in_tod     (split_tod),
      .out_fields (tod_fields)
   );

   jsct_date u_date (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (split_valid),
      .in_day_num (split_day_num),
      .out_valid  (date_valid),
      .out_date   (date_fields)
   );

   // Delay the time fields so they leave with the matching date
   always_ff @(posedge clock) begin
      tod_dly_ff[0] <= tod_fields;
      for (int i = 1; i < jsct_pkg::TOD_ALIGN; i++) begin
         tod_dly_ff[i] <= tod_dly_ff[i-1];
      end
   end

   assign rsp_valid            = date_valid;
   assign rsp_year             = date_fields.year;
   assign rsp_month            = date_fields.month;
   assign rsp_day_of_month     = date_fields.dom;
   assign rsp_status           = date_fields.status;
   assign rsp_hour             = tod_dly_ff[jsct_pkg::TOD_ALIGN-1].hour;
   assign rsp_minute           = tod_dly_ff[jsct_pkg::TOD_ALIGN-1].minute;
   assign rsp_second_of_minute = tod_dly_ff[jsct_pkg::TOD_ALIGN-1].sec;

   `JSCT_ASSERT_IMP(a_time_range, clock, reset, rsp_valid, rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second_of_minute <= 6'd59, "time of day out of range")
   `JSCT_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, rsp_status == jsct_pkg::STATUS_OK || rsp_status == jsct_pkg::STATUS_BEFORE || rsp_status == jsct_pkg::STATUS_AFTER, "undefined status code")
   `JSCT_ASSERT_IMP(a_february, clock, reset, rsp_valid && rsp_status == jsct_pkg::STATUS_OK && rsp_month == 4'd2, rsp_day_of_month <= 5'd29, "February day out of range")

endmodule

/* sv/jsct_day_split.sv */
`timescale 1ns / 1ps
// jsct_day_split: five-stage split of Julian seconds into day number and second of day.
// Depends on jsct_pkg and julian_seconds_to_civil_time_assert.svh.
`include "julian_seconds_to_civil_time_assert.svh"

module jsct_day_split (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [jsct_pkg::SECS_W-1:0]    in_secs,
   output logic                           out_valid,
   output logic [jsct_pkg::DAY_NUM_W-1:0] out_day_num,
   output logic [jsct_pkg::TOD_W-1:0]     out_tod
);

   logic [4:0]  valid_ff, valid_in;

   logic [39:0] a_ff, a_in;
   logic [20:0] xh_ff, xh_in;
   logic [42:0] p1_ff, p1_in;
   logic [18:0] lo2_ff;
   logic [11:0] qh_ff, qh_in;
   logic [9:0]  rh_ff, rh_in;
   logic [18:0] lo3_ff;
   logic [21:0] v2_ff, v2_in;
   logic [44:0] p2_ff, p2_in;
   logic [11:0] qh4_ff;
   logic [6:0]  lo4_ff;
   logic [23:0] q_ff, q_in;
   logic [16:0] tod_ff, tod_in;

   logic [21:0] rh_full;
   logic [11:0] q2;
   logic [21:0] r2_full;

   assign valid_in = {valid_ff[3:0], in_valid};

   always_comb begin
      a_in    = {1'b0, in_secs} + jsct_pkg::TOD_BIAS;
      xh_in   = a_ff[39:19];
      p1_in   = 43'(xh_in) * 43'(jsct_pkg::XH_M);
      qh_in   = p1_ff[42:31];
      rh_full = {1'b0, xh_ff} - 22'(qh_in) * 22'(jsct_pkg::DAY_FRAC);
      rh_in   = rh_full[9:0];
      v2_in   = {rh_ff, lo3_ff[18:7]};
      p2_in   = 45'(v2_in) * 45'(jsct_pkg::V2_M);
      q2      = p2_ff[43:32];
      r2_full = v2_ff - 22'(q2) * 22'(jsct_pkg::DAY_FRAC);
      tod_in  = {r2_full[9:0], lo4_ff};
      q_in    = {qh4_ff, q2};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      xh_ff  <= xh_in;
      p1_ff  <= p1_in;
      lo2_ff <= a_ff[18:0];
      qh_ff  <= qh_in;
      rh_ff  <= rh_in;
      lo3_ff <= lo2_ff;
      v2_ff  <= v2_in;
      p2_ff  <= p2_in;
      qh4_ff <= qh_ff;
      lo4_ff <= lo3_ff[6:0];
      q_ff   <= q_in;
      tod_ff <= tod_in;
   end

   assign out_valid   = valid_ff[4];
   assign out_day_num = q_ff;
   assign out_tod     = tod_ff;

   `JSCT_ASSERT_IMP(a_rem_hi_range, clock, reset, valid_ff[2], rh_ff < 10'd675, "high remainder out of range")
   `JSCT_ASSERT_IMP(a_quot_hi_range, clock, reset, valid_ff[2], qh_ff <= 12'd3106, "high quotient out of range")
   `JSCT_ASSERT_IMP(a_tod_range, clock, reset, valid_ff[4], tod_ff < 17'd86400, "second of day out of range")

endmodule

/* sv/jsct_tod.sv */
`timescale 1ns / 1ps
// jsct_tod: four-stage split of the second of day into hour, minute and second.
// Depends on jsct_pkg.

module jsct_tod (
   input  logic                           clock,
   input  logic [jsct_pkg::TOD_W-1:0]     in_tod,
   output jsct_pkg::tod_fields_type       out_fields
);

   logic [34:0] ph_ff, ph_in;
   logic [16:0] tod_ff;
   logic [4:0]  hour7_ff, hour7_in;
   logic [11:0] remh7_ff, remh7_in;
   logic [24:0] pm_ff, pm_in;
   logic [4:0]  hour8_ff;
   logic [11:0] remh8_ff;
   jsct_pkg::tod_fields_type fields_ff, fields_in;

   logic [16:0] remh_full;
   logic [11:0] sec_full;

   always_comb begin
      ph_in     = 35'(in_tod) * 35'(jsct_pkg::HOUR_M);
      hour7_in  = ph_ff[33:29];
      remh_full = tod_ff - 17'(hour7_in) * jsct_pkg::SECS_PER_HOUR;
      remh7_in  = remh_full[11:0];
      pm_in     = 25'(remh7_ff) * 25'(jsct_pkg::MIN_M);
      fields_in.hour   = hour8_ff;
      fields_in.minute = pm_ff[23:18];
      sec_full         = remh8_ff - 12'(fields_in.minute) * jsct_pkg::SECS_PER_MIN;
      fields_in.sec    = sec_full[5:0];
   end

   always_ff @(posedge clock) begin
      ph_ff     <= ph_in;
      tod_ff    <= in_tod;
      hour7_ff  <= hour7_in;
      remh7_ff  <= remh7_in;
      pm_ff     <= pm_in;
      hour8_ff  <= hour7_ff;
      remh8_ff  <= remh7_ff;
      fields_ff <= fields_in;
   end

   assign out_fields = fields_ff;

endmodule

/* sv/jsct_date.sv */
`timescale 1ns / 1ps
// jsct_date: ten-stage conversion of a day number into Gregorian year, month and day.
// Depends on jsct_pkg and julian_seconds_to_civil_time_assert.svh.
`include "julian_seconds_to_civil_time_assert.svh"

module jsct_date (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [jsct_pkg::DAY_NUM_W-1:0] in_day_num,
   output logic                           out_valid,
   output jsct_pkg::date_fields_type      out_date
);

   logic [9:0]  valid_ff, valid_in;

   // Stage 6
   logic        before6_ff, before6_in;
   logic [22:0] z6_ff, z6_in;
   // Stage 7
   logic        before7_ff;
   logic [22:0] z7_ff;
   logic [46:0] pe7_ff, pe7_in;
   // Stage 8
   logic        before8_ff;
   logic [4:0]  era8_ff, era8_in;
   logic [17:0] doe8_ff, doe8_in;
   // Stage 9
   logic        before9_ff;
   logic [4:0]  era9_ff;
   logic [17:0] doe9_ff;
   logic [36:0] p4_ff, p4_in, p100_ff, p100_in, p400_ff, p400_in;
   // Stage 10
   logic        before10_ff;
   logic [4:0]  era10_ff;
   logic [17:0] doe10_ff;
   logic [17:0] t10_ff, t10_in;
   // Stage 11
   logic        before11_ff;
   logic [4:0]  era11_ff;
   logic [17:0] doe11_ff;
   logic [36:0] py11_ff, py11_in;
   // Stage 12
   logic        before12_ff;
   logic [4:0]  era12_ff;
   logic [17:0] doe12_ff;
   logic [8:0]  yoe12_ff, yoe12_in;
   // Stage 13
   logic        before13_ff;
   logic [8:0]  doy13_ff, doy13_in;
   logic [13:0] ybase13_ff, ybase13_in;
   // Stage 14
   logic        before14_ff;
   logic [8:0]  doy14_ff;
   logic [13:0] ybase14_ff;
   logic [3:0]  mp14_ff, mp14_in;
   // Stage 15
   jsct_pkg::date_fields_type date_ff, date_in;

   logic [23:0] z_full;
   logic [22:0] doe_full;
   logic [1:0]  cent;
   logic [17:0] yday_base;
   logic [17:0] doy_full;
   logic [8:0]  dom_full;
   logic [13:0] year;
   logic [3:0]  month;

   assign valid_in = {valid_ff[8:0], in_valid};

   always_comb begin
      before6_in = in_day_num < jsct_pkg::DAY_BIAS;
      z_full     = in_day_num - jsct_pkg::Z_OFS;
      z6_in      = z_full[22:0];

      pe7_in     = 47'(z6_ff) * 47'(jsct_pkg::ERA_M);

      era8_in    = pe7_ff[45:41];
      doe_full   = z7_ff - 23'(era8_in) * jsct_pkg::ERA_DAYS;
      doe8_in    = doe_full[17:0];

      p4_in      = 37'(doe8_ff) * 37'(jsct_pkg::C4_M);
      p100_in    = 37'(doe8_ff) * 37'(jsct_pkg::C100_M);
      p400_in    = 37'(doe8_ff) * 37'(jsct_pkg::C400_M);

      // Remove the leap days of the era before dividing by the year length
      t10_in     = doe9_ff - 18'(p4_ff[35:29]) + 18'(p100_ff[36:34]) - 18'(p400_ff[36]);

      py11_in    = 37'(t10_ff) * 37'(jsct_pkg::Y_M);

      yoe12_in   = py11_ff[35:27];

      // Century years inside the era: yoe is below 400
      cent       = 2'(yoe12_ff >= 9'd100) + 2'(yoe12_ff >= 9'd200) + 2'(yoe12_ff >= 9'd300);
      yday_base  = 18'(yoe12_ff) * jsct_pkg::DAYS_PER_YEAR + 18'(yoe12_ff[8:2]) - 18'(cent);
      doy_full   = doe12_ff - yday_base;
      doy13_in   = doy_full[8:0];
      ybase13_in = 14'(era12_ff) * jsct_pkg::YEARS_PER_ERA + 14'(yoe12_ff);
   end

   // Month from March: the last month whose first day is not after doy
   always_comb begin
      mp14_in = '0;
      for (int k = 1; k < 12; k++) begin
         if (doy13_ff >= jsct_pkg::MONTH_START[k]) begin
            mp14_in = 4'(k);
         end
      end
   end

   always_comb begin
      dom_full = doy14_ff - jsct_pkg::MONTH_START[mp14_ff] + 9'd1;
      // January and February belong to the next civil year
      if (mp14_ff < jsct_pkg::MARCH_BASED) begin
         month = mp14_ff + 4'd3;
         year  = ybase14_ff;
      end else begin
         month = mp14_ff - 4'd9;
         year  = ybase14_ff + 14'd1;
      end
      priority if (before14_ff) begin
         date_in = '{year: '0, month: '0, dom: '0, status: jsct_pkg::STATUS_BEFORE};
      end else if (year > jsct_pkg::MAX_YEAR) begin
         date_in = '{year: '0, month: '0, dom: '0, status: jsct_pkg::STATUS_AFTER};
      end else begin
         date_in = '{year: year, month: month, dom: dom_full[4:0],
                     status: jsct_pkg::STATUS_OK};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      before6_ff  <= before6_in;
      z6_ff       <= z6_in;
      before7_ff  <= before6_ff;
      z7_ff       <= z6_ff;
      pe7_ff      <= pe7_in;
      before8_ff  <= before7_ff;
      era8_ff     <= era8_in;
      doe8_ff     <= doe8_in;
      before9_ff  <= before8_ff;
      era9_ff     <= era8_ff;
      doe9_ff     <= doe8_ff;
      p4_ff       <= p4_in;
      p100_ff     <= p100_in;
      p400_ff     <= p400_in;
      before10_ff <= before9_ff;
      era10_ff    <= era9_ff;
      doe10_ff    <= doe9_ff;
      t10_ff      <= t10_in;
      before11_ff <= before10_ff;
      era11_ff    <= era10_ff;
      doe11_ff    <= doe10_ff;
      py11_ff     <= py11_in;
      before12_ff <= before11_ff;
      era12_ff    <= era11_ff;
      doe12_ff    <= doe11_ff;
      yoe12_ff    <= yoe12_in;
      before13_ff <= before12_ff;
      doy13_ff    <= doy13_in;
      ybase13_ff  <= ybase13_in;
      before14_ff <= before13_ff;
      doy14_ff    <= doy13_ff;
      ybase14_ff  <= ybase13_ff;
      mp14_ff     <= mp14_in;
      date_ff     <= date_in;
   end

   assign out_valid = valid_ff[9];
   assign out_date  = date_ff;

   `JSCT_ASSERT_IMP(a_zero_on_error, clock, reset, valid_ff[9] && date_ff.status != jsct_pkg::STATUS_OK, date_ff.year == 14'd0 && date_ff.month == 4'd0 && date_ff.dom == 5'd0, "date fields not cleared on error status")
   `JSCT_ASSERT_IMP(a_date_range, clock, reset, valid_ff[9] && date_ff.status == jsct_pkg::STATUS_OK, date_ff.month >= 4'd1 && date_ff.month <= 4'd12 && date_ff.dom >= 5'd1 && date_ff.dom <= 5'd31 && date_ff.year >= jsct_pkg::MIN_YEAR && date_ff.year <= jsct_pkg::MAX_YEAR, "date out of range")
   `JSCT_ASSERT_NXT(a_before_kept, clock, reset, valid_ff[8] && before14_ff, date_ff.status == jsct_pkg::STATUS_BEFORE, "early input lost its status")

endmodule

/* tb/julian_seconds_to_civil_time_tb.sv */
`timescale 1ns / 1ps
// julian_seconds_to_civil_time_tb: self-checking bench for the Julian seconds to civil time
// converter. Predicts each date and time of day and checks every strobed result in order.
// Depends on jsct_pkg and the julian_seconds_to_civil_time top level.
module julian_seconds_to_civil_time_tb;

   // Julian second of 1900-01-01 00:00:00 (Julian day 2415020.5)
   localparam longint unsigned JD_1900_SECS    = 64'd208657771200;
   localparam longint unsigned DAY_SECS        = 64'd86400;
   // First second of year 10000 and the largest 39-bit count
   localparam longint unsigned YEAR_10000_SECS = 64'd464269060800;
   localparam longint unsigned SECS_MAX        = (64'd1 << 39) - 64'd1;
   // Days from 1900-01-01 to 10000-01-01
   localparam longint unsigned DAYS_IN_RANGE   = 64'd2958464;
   localparam int unsigned     RANDOM_ITEMS    = 1900;
   localparam int unsigned     WATCHDOG_LIMIT  = 1000;
   localparam int unsigned     DRAIN_CYCLES    = 40;

   typedef struct packed {
      jsct_pkg::date_fields_type date;
      jsct_pkg::tod_fields_type  tod;
   } civil_time_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [38:0] req_julian_secs = '0;
   logic        busy;
   logic        rsp_valid;
   logic [13:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second_of_minute;
   logic [1:0]  rsp_status;

   // Timestamps waiting to be sent, and predicted results waiting to strobe
   logic [38:0]    secs_backlog [$];
   civil_time_type pending_civil [$];

   int unsigned n_items     = 0;
   int unsigned n_taken     = 0;
   int unsigned idle_cycles = 0;
   bit          failed      = 1'b0;

   julian_seconds_to_civil_time u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_julian_secs      (req_julian_secs),
      .rsp_valid            (rsp_valid),
      .rsp_year             (rsp_year),
      .rsp_month            (rsp_month),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_hour             (rsp_hour),
      .rsp_minute           (rsp_minute),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_status           (rsp_status)
   );

   always #5 clock = ~clock;

   // Civil date and time of day for one Julian second count. The calendar part
   // counts days from 0000-03-01 so that the leap day falls at the end of a year.
   function automatic civil_time_type civil_time_of(input logic [38:0] jsecs);
      civil_time_type  res;
      longint unsigned secs, sod, day_idx, zday, era, era_day, era_yr, yr_day;
      longint unsigned mar_mon, mday, mon, yr;
      secs = 64'(jsecs);
      // Julian days begin at noon: shift by half a day for the time of day
      sod = (secs + 64'd43200) % DAY_SECS;
      res.tod.hour   = 5'(sod / 64'd3600);
      res.tod.minute = 6'((sod / 64'd60) % 64'd60);
      res.tod.sec    = 6'(sod % 64'd60);
      res.date       = '0;
      if (secs < JD_1900_SECS) begin
         res.date.status = jsct_pkg::STATUS_BEFORE;
      end else begin
         day_idx = (secs - JD_1900_SECS) / DAY_SECS;
         zday    = day_idx + 64'd693901;
         era     = zday / 64'd146097;
         era_day = zday - era * 64'd146097;
         era_yr  = (era_day - era_day / 64'd1460 + era_day / 64'd36524
                    - era_day / 64'd146096) / 64'd365;
         yr_day  = era_day - (64'd365 * era_yr + era_yr / 64'd4 - era_yr / 64'd100);
         mar_mon = (64'd5 * yr_day + 64'd2) / 64'd153;
         mday    = yr_day - (64'd153 * mar_mon + 64'd2) / 64'd5 + 64'd1;
         mon     = (mar_mon < 64'd10) ? mar_mon + 64'd3 : mar_mon - 64'd9;
         yr      = era_yr + era * 64'd400 + ((mon <= 64'd2) ? 64'd1 : 64'd0);
         if (yr > 64'(jsct_pkg::MAX_YEAR)) begin
            res.date.status = jsct_pkg::STATUS_AFTER;
         end else begin
            res.date.status = jsct_pkg::STATUS_OK;
            res.date.year   = 14'(yr);
            res.date.month  = 4'(mon);
            res.date.dom    = 5'(mday);
         end
      end
      return res;
   endfunction

   function automatic logic [38:0] any_secs();
      return {7'($urandom_range(127, 0)), 32'($urandom())};
   endfunction

   // Uniform pick in [lo, hi]; the modulo bias is harmless at these spans
   function automatic logic [38:0] secs_between(input longint unsigned lo,
                                                input longint unsigned hi);
      longint unsigned raw;
      raw = {$urandom(), $urandom()};
      return 39'(lo + raw % (hi - lo + 64'd1));
   endfunction

   // Seconds near a midnight or noon boundary of a random day in range
   function automatic logic [38:0] secs_near_boundary();
      longint unsigned base;
      base = JD_1900_SECS + 64'($urandom_range(DAYS_IN_RANGE - 1, 0)) * DAY_SECS;
      case ($urandom_range(4, 0))
         0:       return 39'(base);
         1:       return 39'(base - 64'd1);
         2:       return 39'(base + 64'd43199);
         3:       return 39'(base + 64'd43200);
         default: return 39'(base + 64'($urandom_range(120, 0)));
      endcase
   endfunction

   // Sender idle rate by phase: light idling, then heavy, then none
   function automatic int unsigned idle_pct();
      if (n_taken < n_items / 3)
         return 21;
      else if (n_taken < 2 * n_items / 3)
         return 59;
      else
         return 0;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         failed = 1'b1;
      end
   endtask

   // Driver: record the transaction taken at this edge, then hold, load or idle.
   // Hold a request that was not taken; only roll for idling between items.
   always @(posedge clock) begin : driver
      logic taken;
      logic go;
      taken = !reset && start && !busy;
      if (taken) begin
         pending_civil.push_back(civil_time_of(req_julian_secs));
         n_taken = n_taken + 1;
      end
      go = 1'b0;
      if (reset) begin
         go = 1'b0;
      end else if (start && !taken) begin
         go = 1'b1;
      end else if (secs_backlog.size() != 0 && $urandom_range(99, 0) >= idle_pct()) begin
         go = 1'b1;
         req_julian_secs <= secs_backlog.pop_front();
      end
      // One nonblocking write per edge keeps back-to-back transactions glitch free
      start <= go;
   end

   // Monitor: every strobe must match the oldest prediction. The pipeline is
   // registered stage by stage, so a prediction is always queued before its result.
   always @(posedge clock) begin : monitor
      civil_time_type want;
      if (!reset && rsp_valid) begin
         if (pending_civil.size() == 0) begin
            $error("result strobed with no transaction outstanding");
            failed = 1'b1;
         end else begin
            want = pending_civil.pop_front();
            check_field("year", want.date.year, rsp_year);
            check_field("month", want.date.month, rsp_month);
            check_field("day_of_month", want.date.dom, rsp_day_of_month);
            check_field("hour", want.tod.hour, rsp_hour);
            check_field("minute", want.tod.minute, rsp_minute);
            check_field("second_of_minute", want.tod.sec, rsp_second_of_minute);
            check_field("status", want.date.status, rsp_status);
         end
      end
   end

   // Watchdog: count edges where neither side moves a transaction
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("[julian_seconds_to_civil_time] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned pick;
      // Directed: field extremes, the bounds of years 1900 and 9999, midnight and noon,
      // the skipped leap day of 1900 and 2100 and the kept one of 2000
      secs_backlog.push_back(39'd0);
      secs_backlog.push_back(39'(SECS_MAX));
      secs_backlog.push_back(39'h2A_AAAA_AAAA);
      secs_backlog.push_back(39'h55_5555_5555);
      secs_backlog.push_back(39'(JD_1900_SECS - 64'd1));
      secs_backlog.push_back(39'(JD_1900_SECS));
      secs_backlog.push_back(39'(JD_1900_SECS + 64'd43199));
      secs_backlog.push_back(39'(JD_1900_SECS + 64'd43200));
      secs_backlog.push_back(39'(JD_1900_SECS + DAY_SECS - 64'd1));
      secs_backlog.push_back(39'(JD_1900_SECS + DAY_SECS));
      secs_backlog.push_back(39'(JD_1900_SECS + 64'd59 * DAY_SECS - 64'd1));
      secs_backlog.push_back(39'(JD_1900_SECS + 64'd59 * DAY_SECS));
      secs_backlog.push_back(39'(JD_1900_SECS + 64'd36583 * DAY_SECS));
      secs_backlog.push_back(39'(JD_1900_SECS + 64'd36584 * DAY_SECS));
      secs_backlog.push_back(39'(JD_1900_SECS + 64'd36890 * DAY_SECS - 64'd1));
      secs_backlog.push_back(39'(JD_1900_SECS + 64'd73108 * DAY_SECS - 64'd1));
      secs_backlog.push_back(39'(JD_1900_SECS + 64'd73108 * DAY_SECS));
      secs_backlog.push_back(39'(YEAR_10000_SECS - 64'd1));
      secs_backlog.push_back(39'(YEAR_10000_SECS));
      secs_backlog.push_back(39'(JD_1900_SECS + 64'd3599));
      secs_backlog.push_back(39'(JD_1900_SECS + 64'd3600));

      // Random: half valid dates, the rest the boundaries, both out-of-range
      // sides and raw 39-bit counts so every input bit toggles
      repeat (RANDOM_ITEMS) begin
         pick = $urandom_range(99, 0);
         if (pick < 50)
            secs_backlog.push_back(secs_between(JD_1900_SECS, YEAR_10000_SECS - 64'd1));
         else if (pick < 65)
            secs_backlog.push_back(secs_near_boundary());
         else if (pick < 78)
            secs_backlog.push_back(secs_between(64'd0, JD_1900_SECS - 64'd1));
         else if (pick < 88)
            secs_backlog.push_back(secs_between(YEAR_10000_SECS, SECS_MAX));
         else
            secs_backlog.push_back(any_secs());
      end
      n_items = secs_backlog.size();

      // Hold reset at the start, then release it for good
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last transaction to be taken, drain the pipeline, then
      // keep running to catch any stray strobe
      while (secs_backlog.size() != 0 || start)
         @(posedge clock);
      while (pending_civil.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (!failed)
         $display("[julian_seconds_to_civil_time] OK");
      else
         $display("[julian_seconds_to_civil_time] ERROR");
      $finish;
   end

endmodule
